[rtl/upd_pkg.sv]
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the decoder.
package upd_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int MAX_RES    = 3;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	typedef struct packed {
		logic                          eos;
		logic [1:0]                    cnt;
		logic [MAX_RES-1:0][7:0]       chars;
	} upd_grp_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF))
			|| ((c >= CH_LA) && (c <= CH_LF));
	endfunction

	// letters carry bit 6; their low nibble is one through six
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

endpackage

[rtl/upd_front.sv]
// Front end: accepts characters, tracks open escapes, builds result groups.
// Depends on upd_pkg.
module upd_front import upd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  logic [7:0] char_in,
	input  logic     end_of_string,
	output logic     grp_push,
	output upd_grp_t grp,
	output pend_t    pend
);

	pend_t      pend_q;
	logic [7:0] held_q;
	pend_t      pend_n;
	logic [7:0] held_n;

	assign pend = pend_q;

	always_comb begin
		logic                    consumed;
		logic [1:0]              n;
		logic [MAX_RES-1:0][7:0] chars;
		consumed = 1'b0;
		n        = 2'd0;
		chars    = '0;
		pend_n   = PEND_NONE;
		held_n   = held_q;
		case (pend_q)
			PEND_DIGIT: begin
				if (is_hex(char_in)) begin
					chars[0] = {hex_val(held_q), hex_val(char_in)};
					n        = 2'd1;
					consumed = 1'b1;
				end else begin
					chars[0] = CH_PCT;
					chars[1] = held_q;
					n        = 2'd2;
				end
			end
			PEND_PCT: begin
				if (is_hex(char_in)) begin
					held_n   = char_in;
					pend_n   = PEND_DIGIT;
					consumed = 1'b1;
				end else begin
					chars[0] = CH_PCT;
					n        = 2'd1;
				end
			end
			default: begin
				pend_n = PEND_NONE;
			end
		endcase
		if (!consumed) begin
			if (char_in == CH_PCT) begin
				pend_n = PEND_PCT;
			end else begin
				chars[n] = (char_in == CH_PLUS) ? CH_SPACE : char_in;
				n        = n + 2'd1;
			end
		end
		if (end_of_string) begin
			if (pend_n == PEND_PCT) begin
				chars[n] = CH_PCT;
				n        = n + 2'd1;
			end else if (pend_n == PEND_DIGIT) begin
				chars[n]        = CH_PCT;
				chars[n + 2'd1] = held_n;
				n               = n + 2'd2;
			end
			pend_n = PEND_NONE;
		end
		grp.eos   = end_of_string;
		grp.cnt   = n;
		grp.chars = chars;
		grp_push  = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= '0;
		end else if (accept) begin
			pend_q <= pend_n;
			held_q <= held_n;
		end
	end

endmodule

[rtl/upd_fifo.sv]
// Short queue of result groups between front and back end.
// Depends on upd_pkg.
module upd_fifo import upd_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  upd_grp_t wdata,
	input  logic     pop,
	output upd_grp_t rdata,
	output logic     full,
	output logic     empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upd_grp_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : (p + AW'(1));
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/upd_back.sv]
// Back end: walks each queued group one byte at a time into the output register.
// Depends on upd_pkg.
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  upd_grp_t   head,
	input  logic       head_valid,
	output logic       head_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] char_out,
	output logic       string_done,
	output logic       run_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       done_q;
	logic       last_q;
	logic       load;
	logic       at_last;

	assign load     = head_valid && (!out_valid_q || pop);
	assign at_last  = (idx_q == (head.cnt - 2'd1));
	assign head_pop = load && at_last;

	assign empty       = !out_valid_q;
	assign char_out    = char_q;
	assign string_done = done_q;
	assign run_last    = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.chars[idx_q];
			last_q <= at_last;
			done_q <= at_last && head.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_last ? 2'd0 : (idx_q + 2'd1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/url_percent_decoder.sv]
// Streaming URL percent decoder, top level: front end, group queue, back end.
// Each result is held in the group queue and then in the output register.
// Throughput: one character per cycle while not full; the back end emits one byte
// per cycle while popped; a character yielding two or three bytes holds it longer.
// Reset (arst_n low, asynchronous) clears escape state, queue and output register.
// Depends on upd_pkg, upd_front, upd_fifo, upd_back.
module url_percent_decoder import upd_pkg::*; #(
	parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       end_of_string,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] char_out,
	output logic       string_done,
	output logic       run_last
);

	logic     accept;
	logic     grp_push;
	upd_grp_t grp;
	pend_t    pend;
	upd_grp_t head;
	logic     q_empty;
	logic     head_pop;

	assign accept = push && !full;

	upd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_in       (char_in),
		.end_of_string (end_of_string),
		.grp_push      (grp_push),
		.grp           (grp),
		.pend          (pend)
	);

	upd_fifo #(
		.DEPTH (FIFO_DEPTH_P)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (grp),
		.pop    (head_pop),
		.rdata  (head),
		.full   (full),
		.empty  (q_empty)
	);

	upd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!q_empty),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.char_out    (char_out),
		.string_done (string_done),
		.run_last    (run_last)
	);

	a_eos_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_string) |=> (pend == PEND_NONE))
		else $error("escape state left open after end of string");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_done) |-> run_last)
		else $error("string_done without run_last");

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (head.cnt != 2'd0))
		else $error("empty group in queue");

	a_eos_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_string) |-> grp_push)
		else $error("end of string produced no item");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_decoder: directed table, then random strings.
// Predicts decoded bytes per accepted item and checks every popped result in order.
// Depends on upd_pkg and the decoder RTL.
module tb import upd_pkg::*; ();

	typedef struct packed {
		logic [7:0] ch;
		logic       done;
		logic       last;
	} dec_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
		logic       typed;
		logic [7:0] want;
	} row_t;

	localparam int N_DIR   = 25;
	localparam int N_PHASE = 49;
	localparam int HOLD_CYC = 60;

	localparam logic [17:0] DIR_ROWS [0:N_DIR-1] = '{
		{"a",     1'b0, 1'b1, "a"},
		{CH_PLUS, 1'b0, 1'b1, CH_SPACE},
		{8'h00,   1'b0, 1'b1, 8'h00},
		{8'hFF,   1'b0, 1'b1, 8'hFF},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"4",     1'b0, 1'b0, 8'h00},
		{"1",     1'b0, 1'b1, 8'h41},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"f",     1'b0, 1'b0, 8'h00},
		{"F",     1'b0, 1'b1, 8'hFF},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"G",     1'b0, 1'b0, 8'h00},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"a",     1'b0, 1'b0, 8'h00},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"2",     1'b0, 1'b0, 8'h00},
		{"0",     1'b0, 1'b1, CH_SPACE},
		{CH_PCT,  1'b1, 1'b1, CH_PCT},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"9",     1'b1, 1'b0, 8'h00},
		{CH_PLUS, 1'b1, 1'b1, CH_SPACE},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{CH_PCT,  1'b0, 1'b0, 8'h00},
		{"1",     1'b0, 1'b0, 8'h00},
		{"z",     1'b1, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       end_of_string = 1'b0;
	logic       pop = 1'b0;
	logic       empty;
	logic [7:0] char_out;
	logic       string_done;
	logic       run_last;

	logic       typed_valid = 1'b0;
	logic [7:0] typed_char = 8'h00;

	pend_t      esc_state = PEND_NONE;
	logic [7:0] esc_digit = 8'h00;
	dec_byte_t  decoded_q [$];
	dec_byte_t  head_byte;
	int         mismatches = 0;
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;
	int         hold_requests = 0;
	int         holds_done = 0;

	url_percent_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_in      (char_in),
		.end_of_string(end_of_string),
		.pop          (pop),
		.empty        (empty),
		.char_out     (char_out),
		.string_done  (string_done),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	function automatic logic hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] u;
		u = (c >= "a") ? c - 8'd32 : c;
		return (u >= "A") ? 4'(u - "A" + 8'd10) : 4'(u - "0");
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic eos, input logic keep);
		logic [2:0][7:0] outs;
		int              n;
		logic            used;
		n = 0;
		used = 1'b0;
		outs = '0;
		case (esc_state)
			PEND_DIGIT: begin
				if (hex_char(c)) begin
					outs[n] = {nibble_of(esc_digit), nibble_of(c)};
					n++;
					used = 1'b1;
				end else begin
					outs[n] = CH_PCT;
					n++;
					outs[n] = esc_digit;
					n++;
				end
				esc_state = PEND_NONE;
			end
			PEND_PCT: begin
				if (hex_char(c)) begin
					esc_digit = c;
					esc_state = PEND_DIGIT;
					used = 1'b1;
				end else begin
					outs[n] = CH_PCT;
					n++;
					esc_state = PEND_NONE;
				end
			end
			default: esc_state = PEND_NONE;
		endcase
		if (!used) begin
			if (c == CH_PCT) begin
				esc_state = PEND_PCT;
			end else begin
				outs[n] = (c == CH_PLUS) ? CH_SPACE : c;
				n++;
			end
		end
		if (eos) begin
			if (esc_state != PEND_NONE) begin
				outs[n] = CH_PCT;
				n++;
			end
			if (esc_state == PEND_DIGIT) begin
				outs[n] = esc_digit;
				n++;
			end
			esc_state = PEND_NONE;
		end
		if (keep) begin
			for (int i = 0; i < n; i++)
				decoded_q.push_back('{outs[i], eos && (i == n - 1), i == n - 1});
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				decode_char(char_in, end_of_string, !typed_valid);
				if (typed_valid)
					decoded_q.push_back('{typed_char, end_of_string, 1'b1});
			end
			if (pop && !empty) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got char %h done %b last %b",
						$time, char_out, string_done, run_last);
					mismatches++;
				end else begin
					head_byte = decoded_q.pop_front();
					if (char_out !== head_byte.ch) begin
						$display("%0t: char_out expected %h got %h", $time, head_byte.ch, char_out);
						mismatches++;
					end
					if (string_done !== head_byte.done) begin
						$display("%0t: string_done expected %b got %b", $time, head_byte.done,
							string_done);
						mismatches++;
					end
					if (run_last !== head_byte.last) begin
						$display("%0t: run_last expected %b got %b", $time, head_byte.last, run_last);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				pop <= 1'b0;
				for (int k = 1; k < HOLD_CYC; k++)
					@(negedge clk);
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic eos, input logic tv,
			input logic [7:0] tc);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		char_in <= c;
		end_of_string <= eos;
		typed_valid <= tv;
		typed_char <= tc;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (decoded_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		row_t       r;
		logic [7:0] c;
		logic       e;
		int         want_hex;
		int         sel;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIR; i++) begin
			r = DIR_ROWS[i];
			send_item(r.ch, r.eos, r.typed, r.want);
		end
		wait_drained();
		want_hex = 0;
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 8 : 0;
			rx_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 8 : 0;
			for (int i = 0; i < N_PHASE; i++) begin
				if (ph == 0 && i == 10)
					hold_requests++;
				sel = $urandom_range(0, 99);
				if (want_hex > 0 && sel < 85) begin
					sel = $urandom_range(0, 21);
					c = (sel < 10) ? 8'("0" + sel) : (sel < 16) ? 8'("a" + sel - 10)
						: 8'("A" + sel - 16);
					want_hex--;
				end else if (want_hex > 0) begin
					c = 8'($urandom_range(0, 255));
					want_hex = 0;
				end else if (sel < 30) begin
					c = CH_PCT;
					want_hex = 2;
				end else if (sel < 40) begin
					c = CH_PLUS;
				end else if (sel < 46) begin
					c = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
				end else begin
					c = 8'($urandom_range(0, 255));
				end
				e = ($urandom_range(0, 11) == 0);
				if (e)
					want_hex = 0;
				send_item(c, e, 1'b0, 8'h00);
			end
			wait_drained();
		end
		repeat (6) @(negedge clk);
		if (decoded_q.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, decoded_q.size());
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[sim.f]
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_fifo.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/tb.sv
